@@ rtl/lfdc_pkg.sv @@
package lfdc_pkg;

  // Queue between the front and the back
  localparam int QUEUE_DEPTH = 2;

  localparam int SPEED_W   = 8;
  localparam int TIMEOUT_W = 16;
  localparam int TRIM_W    = 7;
  localparam int STAMP_W   = 32;
  localparam int MODE_W    = 3;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 16;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CRUISE         = 3'd0,
    REG_PIVOT          = 3'd1,
    REG_HARD_PIVOT     = 3'd2,
    REG_CREEP          = 3'd3,
    REG_SWEEP          = 3'd4,
    REG_SEARCH_TIMEOUT = 3'd5,
    REG_SHARP_TIMEOUT  = 3'd6,
    REG_RIGHT_TRIM     = 3'd7
  } cfg_reg_t;

  // Drive modes as seen on mode_now
  typedef enum logic [MODE_W-1:0] {
    MODE_FOLLOW   = 3'd0,
    MODE_SEARCH_L = 3'd1,
    MODE_SEARCH_R = 3'd2,
    MODE_LOST     = 3'd3,
    MODE_SHARP_L  = 3'd4,
    MODE_SHARP_R  = 3'd5
  } mode_t;

  // Recovery phases while lost
  typedef enum logic [1:0] {
    PHASE_SPIN  = 2'd0,
    PHASE_WEAVE = 2'd1,
    PHASE_WIDE  = 2'd2
  } phase_t;

  // Back end sequencer
  typedef enum logic [1:0] {
    BK_IDLE   = 2'd0,
    BK_DECIDE = 2'd1,
    BK_SCALE  = 2'd2,
    BK_DIVIDE = 2'd3
  } back_state_t;

  // One classified control tick
  typedef struct packed {
    logic [2:0]         sensors;  // left, middle, right
    logic               any_line;
    logic [STAMP_W-1:0] now_ms;
  } item_t;

endpackage

@@ rtl/lfdc_front.sv @@
module lfdc_front (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              sensor_left,
  input  logic                              sensor_middle,
  input  logic                              sensor_right,
  input  logic [lfdc_pkg::STAMP_W-1:0]      now_ms,
  output logic                              push,
  output lfdc_pkg::item_t                   push_item,
  input  logic                              queue_full
);
  import lfdc_pkg::*;

  logic  hold_valid;
  item_t hold_item;

  // Forward the held word whenever the queue has room
  assign push      = hold_valid && !queue_full;
  assign push_item = hold_item;
  assign in_ready  = !hold_valid || push;

  // Hold flag
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      hold_valid <= 1'b1;
    end else if (push) begin
      hold_valid <= 1'b0;
    end
  end

  // Capture and classify the incoming word
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      hold_item.sensors  <= {sensor_left, sensor_middle, sensor_right};
      hold_item.any_line <= sensor_left | sensor_middle | sensor_right;
      hold_item.now_ms   <= now_ms;
    end
  end

endmodule

@@ rtl/lfdc_queue.sv @@
module lfdc_queue #(
  parameter int DEPTH = lfdc_pkg::QUEUE_DEPTH
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  lfdc_pkg::item_t push_item,
  output logic            full,
  input  logic            pop,
  output lfdc_pkg::item_t pop_item,
  output logic            not_empty
);
  import lfdc_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

  item_t            store [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full      = (count == CNT_W'(DEPTH));
  assign not_empty = (count != '0);
  assign pop_item  = store[rd_ptr];

  // Advance pointers and count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  // Write storage
  always_ff @(posedge clk) begin
    if (push) begin
      store[wr_ptr] <= push_item;
    end
  end

endmodule

@@ rtl/lfdc_back.sv @@
module lfdc_back (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_write,
  input  logic [lfdc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [lfdc_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic                              item_valid,
  input  lfdc_pkg::item_t                   item,
  output logic                              item_pop,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic                              drive_update,
  output logic                              left_forward,
  output logic [7:0]                        left_duty,
  output logic                              right_forward,
  output logic [7:0]                        right_duty,
  output logic [lfdc_pkg::MODE_W-1:0]       mode_now
);
  import lfdc_pkg::*;

  localparam logic [12:0] RECIP_TEN     = 13'd6554;  // 2^16 / 10, rounded up
  localparam logic [12:0] RECIP_HUNDRED = 13'd5243;  // 2^19 / 100, rounded up
  localparam logic [31:0] LOSS_DEBOUNCE_MS = 32'd50;
  localparam logic [31:0] SEARCH_FULL_MS   = 32'd200;
  localparam logic [31:0] SEARCH_MID_MS    = 32'd500;
  localparam logic [31:0] SPIN_MS          = 32'd800;
  localparam logic [31:0] WEAVE_MS         = 32'd600;
  localparam logic [31:0] WEAVE_END_MS     = 32'd1200;
  localparam logic [31:0] WIDE_MS          = 32'd2000;
  localparam logic [8:0]  SLIGHT_BOOST     = 9'd20;
  localparam logic [1:0]  SHARP_LIMIT      = 2'd3;

  // floor(speed * k / 10)
  function automatic logic [7:0] tenths(input logic [7:0] speed, input logic [3:0] k);
    logic [11:0] prod;
    logic [24:0] scaled;
    prod   = 12'(speed) * 12'(k);
    scaled = 25'(prod) * 25'(RECIP_TEN);
    return scaled[23:16];
  endfunction

  // Configuration registers
  logic [SPEED_W-1:0]   cruise_spd, pivot_spd, hard_pivot_spd, creep_spd, sweep_spd;
  logic [TIMEOUT_W-1:0] search_timeout_ms, sharp_turn_timeout_ms;
  logic [TRIM_W-1:0]    right_trim_percent;

  // Controller state
  mode_t              mode, mode_next;
  logic [STAMP_W-1:0] search_start, search_start_next;
  logic [STAMP_W-1:0] turn_start, turn_start_next;
  logic [STAMP_W-1:0] recovery_start, recovery_start_next;
  phase_t             recovery_phase, recovery_phase_next;
  logic [STAMP_W-1:0] loss_start, loss_start_next;
  logic               loss_pending, loss_pending_next;
  logic               had_line, had_line_next;
  logic [2:0]         prior_sensors, prior_sensors_next;
  logic [1:0]         sharp_count, sharp_count_next;

  back_state_t bk_state, bk_next;
  item_t       cur;

  // Command in sign and magnitude form
  logic       cmd_valid, cmd_valid_next;
  logic       left_neg, left_neg_next, right_neg, right_neg_next;
  logic [8:0] left_mag, left_mag_next, right_mag, right_mag_next;
  logic [15:0] trim_prod;
  logic [28:0] trim_scaled;
  logic [9:0]  trim_quot;

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      bk_state <= BK_IDLE;
    end else begin
      bk_state <= bk_next;
    end
  end

  always_comb begin
    bk_next  = bk_state;
    item_pop = 1'b0;
    unique case (bk_state)
      BK_IDLE: begin
        if (item_valid && (!out_valid || out_ready)) begin
          item_pop = 1'b1;
          bk_next  = BK_DECIDE;
        end
      end
      BK_DECIDE: bk_next = BK_SCALE;
      BK_SCALE:  bk_next = BK_DIVIDE;
      BK_DIVIDE: bk_next = BK_IDLE;
      default:   bk_next = BK_IDLE;
    endcase
  end

  // Mode decision for the current word
  always_comb begin
    logic        l, m, r, any;
    logic        pl, pm, pr;
    logic [31:0] now, el_search, el_turn, el_rec, el_loss;
    logic [7:0]  srch_a, srch_c;
    logic        sharp;

    l   = cur.sensors[2];
    m   = cur.sensors[1];
    r   = cur.sensors[0];
    any = cur.any_line;
    now = cur.now_ms;
    pl  = prior_sensors[2];
    pm  = prior_sensors[1];
    pr  = prior_sensors[0];
    el_search = now - search_start;
    el_turn   = now - turn_start;
    el_rec    = now - recovery_start;
    el_loss   = loss_pending ? (now - loss_start) : '0;
    sharp     = had_line && !any;

    if (el_search < SEARCH_FULL_MS) begin
      srch_a = sweep_spd;
      srch_c = sweep_spd;
    end else if (el_search < SEARCH_MID_MS) begin
      srch_a = tenths(sweep_spd, 4'd6);
      srch_c = tenths(sweep_spd, 4'd8);
    end else begin
      srch_a = tenths(sweep_spd, 4'd4);
      srch_c = tenths(sweep_spd, 4'd6);
    end

    mode_next           = mode;
    search_start_next   = search_start;
    turn_start_next     = turn_start;
    recovery_start_next = recovery_start;
    recovery_phase_next = recovery_phase;
    loss_start_next     = loss_start;
    loss_pending_next   = loss_pending;
    had_line_next       = had_line;
    prior_sensors_next  = prior_sensors;
    sharp_count_next    = sharp_count;
    cmd_valid_next      = 1'b0;
    left_neg_next       = 1'b0;
    left_mag_next       = '0;
    right_neg_next      = 1'b0;
    right_mag_next      = '0;

    unique case (mode)
      MODE_FOLLOW: begin
        had_line_next      = any;
        prior_sensors_next = cur.sensors;
        if (sharp && (sharp_count < SHARP_LIMIT)) begin
          // Line vanished: turn toward its last side, or search right if centred
          if (pl && !pr) begin
            mode_next        = MODE_SHARP_L;
            turn_start_next  = now;
            sharp_count_next = sharp_count + 2'd1;
          end else if (pr && !pl) begin
            mode_next        = MODE_SHARP_R;
            turn_start_next  = now;
            sharp_count_next = sharp_count + 2'd1;
          end else if (pm) begin
            mode_next         = MODE_SEARCH_R;
            search_start_next = now;
          end
        end else if (!any) begin
          // Debounce a short loss of line
          if (!loss_pending) begin
            loss_start_next   = now;
            loss_pending_next = 1'b1;
          end
          if (el_loss > LOSS_DEBOUNCE_MS) begin
            mode_next         = MODE_SEARCH_R;
            search_start_next = now;
          end else begin
            cmd_valid_next = 1'b1;
            left_mag_next  = 9'(creep_spd);
            right_mag_next = 9'(creep_spd);
          end
        end else begin
          cmd_valid_next    = 1'b1;
          loss_pending_next = 1'b0;
          sharp_count_next  = '0;
          if (l && !m && !r) begin
            left_neg_next  = (pivot_spd != '0);
            left_mag_next  = 9'(pivot_spd);
            right_mag_next = 9'(pivot_spd);
          end else if (r && !m && !l) begin
            right_neg_next = (pivot_spd != '0);
            left_mag_next  = 9'(pivot_spd);
            right_mag_next = 9'(pivot_spd);
          end else if (l && m && !r) begin
            left_mag_next  = 9'(creep_spd);
            right_mag_next = 9'(cruise_spd) + SLIGHT_BOOST;
          end else if (r && m && !l) begin
            left_mag_next  = 9'(cruise_spd) + SLIGHT_BOOST;
            right_mag_next = 9'(creep_spd);
          end else begin
            left_mag_next  = 9'(cruise_spd);
            right_mag_next = 9'(cruise_spd);
          end
        end
      end
      MODE_SEARCH_L, MODE_SEARCH_R: begin
        cmd_valid_next = 1'b1;
        if (mode == MODE_SEARCH_R) begin
          left_mag_next  = 9'(srch_a);
          right_neg_next = (srch_c != '0);
          right_mag_next = 9'(srch_c);
        end else begin
          left_neg_next  = (srch_c != '0);
          left_mag_next  = 9'(srch_c);
          right_mag_next = 9'(srch_a);
        end
        if (any) begin
          mode_next = MODE_FOLLOW;
        end else if (el_search >= 32'(search_timeout_ms)) begin
          mode_next           = MODE_LOST;
          recovery_phase_next = PHASE_SPIN;
          recovery_start_next = now;
        end
      end
      MODE_SHARP_L, MODE_SHARP_R: begin
        cmd_valid_next = 1'b1;
        left_mag_next  = 9'(hard_pivot_spd);
        right_mag_next = 9'(hard_pivot_spd);
        if (mode == MODE_SHARP_R) begin
          right_neg_next = (hard_pivot_spd != '0);
        end else begin
          left_neg_next = (hard_pivot_spd != '0);
        end
        if (any) begin
          mode_next = MODE_FOLLOW;
        end else if (el_turn >= 32'(sharp_turn_timeout_ms)) begin
          mode_next         = (mode == MODE_SHARP_R) ? MODE_SEARCH_R : MODE_SEARCH_L;
          search_start_next = now;
        end
      end
      MODE_LOST: begin
        if (any) begin
          mode_next = MODE_FOLLOW;
        end else begin
          unique case (recovery_phase)
            PHASE_SPIN: begin
              cmd_valid_next = 1'b1;
              left_neg_next  = (hard_pivot_spd != '0);
              left_mag_next  = 9'(hard_pivot_spd);
              right_mag_next = 9'(hard_pivot_spd);
              if (el_rec > SPIN_MS) begin
                recovery_phase_next = PHASE_WEAVE;
                recovery_start_next = now;
              end
            end
            PHASE_WEAVE: begin
              if (el_rec < WEAVE_MS) begin
                cmd_valid_next = 1'b1;
                left_mag_next  = 9'(tenths(sweep_spd, 4'd8));
                right_mag_next = 9'(tenths(sweep_spd, 4'd3));
              end else if (el_rec < WEAVE_END_MS) begin
                cmd_valid_next = 1'b1;
                left_mag_next  = 9'(tenths(sweep_spd, 4'd3));
                right_mag_next = 9'(tenths(sweep_spd, 4'd8));
              end else begin
                recovery_phase_next = PHASE_WIDE;
                recovery_start_next = now;
              end
            end
            PHASE_WIDE: begin
              cmd_valid_next = 1'b1;
              left_neg_next  = (pivot_spd != '0);
              left_mag_next  = 9'(pivot_spd);
              right_mag_next = 9'(pivot_spd);
              if (el_rec > WIDE_MS) begin
                recovery_phase_next = PHASE_SPIN;
                recovery_start_next = now;
                mode_next           = MODE_SEARCH_R;
                search_start_next   = now;
              end
            end
            default: begin
            end
          endcase
        end
      end
      default: begin
      end
    endcase
  end

  // Controller state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      mode           <= MODE_FOLLOW;
      search_start   <= '0;
      turn_start     <= '0;
      recovery_start <= '0;
      recovery_phase <= PHASE_SPIN;
      loss_start     <= '0;
      loss_pending   <= 1'b0;
      had_line       <= 1'b0;
      prior_sensors  <= '0;
      sharp_count    <= '0;
    end else if (bk_state == BK_DECIDE) begin
      mode           <= mode_next;
      search_start   <= search_start_next;
      turn_start     <= turn_start_next;
      recovery_start <= recovery_start_next;
      recovery_phase <= recovery_phase_next;
      loss_start     <= loss_start_next;
      loss_pending   <= loss_pending_next;
      had_line       <= had_line_next;
      prior_sensors  <= prior_sensors_next;
      sharp_count    <= sharp_count_next;
    end
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cruise_spd            <= 8'd210;
      pivot_spd             <= 8'd200;
      hard_pivot_spd        <= 8'd175;
      creep_spd             <= 8'd190;
      sweep_spd             <= 8'd190;
      search_timeout_ms     <= 16'd800;
      sharp_turn_timeout_ms <= 16'd1200;
      right_trim_percent    <= 7'd94;
    end else if (cfg_write) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_CRUISE:         cruise_spd            <= cfg_data[SPEED_W-1:0];
        REG_PIVOT:          pivot_spd             <= cfg_data[SPEED_W-1:0];
        REG_HARD_PIVOT:     hard_pivot_spd        <= cfg_data[SPEED_W-1:0];
        REG_CREEP:          creep_spd             <= cfg_data[SPEED_W-1:0];
        REG_SWEEP:          sweep_spd             <= cfg_data[SPEED_W-1:0];
        REG_SEARCH_TIMEOUT: search_timeout_ms     <= cfg_data[TIMEOUT_W-1:0];
        REG_SHARP_TIMEOUT:  sharp_turn_timeout_ms <= cfg_data[TIMEOUT_W-1:0];
        REG_RIGHT_TRIM:     right_trim_percent    <= cfg_data[TRIM_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Datapath: latch word, decide, scale right side, divide by 100
  assign trim_scaled = 29'(trim_prod) * 29'(RECIP_HUNDRED);
  assign trim_quot   = trim_scaled[28:19];

  always_ff @(posedge clk) begin
    if (item_pop) begin
      cur <= item;
    end
    if (bk_state == BK_DECIDE) begin
      cmd_valid <= cmd_valid_next;
      left_neg  <= left_neg_next;
      left_mag  <= left_mag_next;
      right_neg <= right_neg_next;
      right_mag <= right_mag_next;
    end
    if (bk_state == BK_SCALE) begin
      trim_prod <= 16'(right_mag) * 16'(right_trim_percent);
    end
    if (bk_state == BK_DIVIDE) begin
      drive_update  <= cmd_valid;
      left_forward  <= cmd_valid && !left_neg;
      left_duty     <= !cmd_valid ? 8'd0 : (left_mag > 9'd255) ? 8'd255 : left_mag[7:0];
      right_forward <= cmd_valid && !right_neg;
      right_duty    <= !cmd_valid ? 8'd0 : (trim_quot > 10'd255) ? 8'd255 : trim_quot[7:0];
      mode_now      <= mode;
    end
  end

  // Output word valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (bk_state == BK_DIVIDE) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

endmodule

@@ rtl/line_follower_drive_controller.sv @@
// Drive controller for a three-sensor line follower.
// Input channel (in_valid/in_ready) carries one control tick per word: the
// three line sensor bits and a millisecond timestamp. Output channel
// (out_valid/out_ready) returns exactly one word per tick: drive_update, the
// direction and duty of each motor, and the mode after the tick. When
// drive_update is low the direction and duty fields are zero.
// The config port (cfg_write, cfg_index, cfg_data) writes one register per
// cycle with no wait; write it only while no tick is in flight.
// From input acceptance to out_valid a word moves from the input register into
// the queue, then through the back-end sequencer (pop, mode decision, right
// trim multiply, divide by 100 and saturate).
// The sequencer takes a new word only once it is through with the last; the input
// register and the queue keep accepting while a result waits.
// Reset (rst, synchronous) clears the mode state, restores the register
// defaults and empties the queue and output register.
// If the receiver stalls, the result holds on the outputs, the back end stops
// before its next word, and in_ready drops once the queue and input register fill.
module line_follower_drive_controller #(
  parameter int QUEUE_DEPTH = lfdc_pkg::QUEUE_DEPTH
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_write,
  input  logic [lfdc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [lfdc_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            sensor_left,
  input  logic                            sensor_middle,
  input  logic                            sensor_right,
  input  logic [lfdc_pkg::STAMP_W-1:0]    now_ms,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic                            drive_update,
  output logic                            left_forward,
  output logic [7:0]                      left_duty,
  output logic                            right_forward,
  output logic [7:0]                      right_duty,
  output logic [lfdc_pkg::MODE_W-1:0]     mode_now
);
  import lfdc_pkg::*;

  logic  push, queue_full, pop, queue_valid;
  item_t push_item, pop_item;

  lfdc_front u_front (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .sensor_left   (sensor_left),
    .sensor_middle (sensor_middle),
    .sensor_right  (sensor_right),
    .now_ms        (now_ms),
    .push          (push),
    .push_item     (push_item),
    .queue_full    (queue_full)
  );

  lfdc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .full      (queue_full),
    .pop       (pop),
    .pop_item  (pop_item),
    .not_empty (queue_valid)
  );

  lfdc_back u_back (
    .clk           (clk),
    .rst           (rst),
    .cfg_write     (cfg_write),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .item_valid    (queue_valid),
    .item          (pop_item),
    .item_pop      (pop),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .drive_update  (drive_update),
    .left_forward  (left_forward),
    .left_duty     (left_duty),
    .right_forward (right_forward),
    .right_duty    (right_duty),
    .mode_now      (mode_now)
  );

endmodule

@@ rtl/lfdc_checker.sv @@
module lfdc_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            in_valid,
  input logic                            in_ready,
  input logic                            out_valid,
  input logic                            out_ready,
  input logic                            drive_update,
  input logic                            left_forward,
  input logic [7:0]                      left_duty,
  input logic                            right_forward,
  input logic [7:0]                      right_duty,
  input logic [lfdc_pkg::MODE_W-1:0]     mode_now
);
  import lfdc_pkg::*;

  logic [7:0] in_flight;

  // Count words accepted but not yet delivered
  always_ff @(posedge clk) begin
    if (rst) begin
      in_flight <= '0;
    end else begin
      in_flight <= in_flight + 8'(in_valid && in_ready) - 8'(out_valid && out_ready);
    end
  end

  // Reset empties the output register
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid after reset");

  // No result without an accepted word behind it
  a_no_phantom: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_flight != '0)
    else $error("result word without a pending input word");

  // A tick without a motor command carries zero drive fields
  a_idle_fields: assert property (@(posedge clk) disable iff (rst)
    out_valid && !drive_update |->
      !left_forward && !right_forward && left_duty == '0 && right_duty == '0)
    else $error("drive fields set without drive_update");

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(drive_update) &&
      $stable(left_duty) && $stable(right_duty) && $stable(mode_now))
    else $error("stalled result changed");

endmodule

bind line_follower_drive_controller lfdc_checker u_checker (.*);
